### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the reorder buffer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### src/rbca_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer package
// Field widths, result codes and the result record shared by the block.
// ----------------------------------------------------------------------------
package rbca_pkg;

	localparam int SEQ_W     = 32;
	localparam int LEN_W     = 11;
	localparam int KIND_W    = 2;
	localparam int VERDICT_W = 3;
	localparam int ENTRY_W   = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_RELEASE = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_EOS     = 2'd2
	} kind_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_IN_ORDER  = 3'd0,
		V_BUFFERED  = 3'd1,
		V_HELD      = 3'd2,
		V_DUPLICATE = 3'd3,
		V_DROPPED   = 3'd4
	} verdict_t;

	typedef struct packed {
		kind_t                kind;
		logic [SEQ_W-1:0]     write_offset;
		logic [LEN_W-1:0]     write_length;
		logic                 from_buffer;
		logic [ENTRY_W-1:0]   source_entry;
		verdict_t             verdict;
		logic [ENTRY_W-1:0]   store_entry;
		logic [SEQ_W-1:0]     ack_number;
		logic                 last;
	} res_t;

	function automatic res_t make_result(
		kind_t              kind,
		logic [SEQ_W-1:0]   off,
		logic [LEN_W-1:0]   len,
		logic               fromb,
		logic [ENTRY_W-1:0] src,
		verdict_t           verdict,
		logic [ENTRY_W-1:0] store,
		logic [SEQ_W-1:0]   ack,
		logic               last
	);
		res_t r;
		r.kind         = kind;
		r.write_offset = off;
		r.write_length = len;
		r.from_buffer  = fromb;
		r.source_entry = src;
		r.verdict      = verdict;
		r.store_entry  = store;
		r.ack_number   = ack;
		r.last         = last;
		return r;
	endfunction

endpackage

### src/rbca_if.sv
// ----------------------------------------------------------------------------
// Reorder buffer channels
// Segment header channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbca_seg_if import rbca_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq_number;
	logic [LEN_W-1:0] data_length;

	modport source (output valid, output seq_number, output data_length, input ready);
	modport sink   (input valid, input seq_number, input data_length, output ready);
endinterface

interface rbca_res_if import rbca_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [SEQ_W-1:0]     write_offset;
	logic [LEN_W-1:0]     write_length;
	logic                 from_buffer;
	logic [ENTRY_W-1:0]   source_entry;
	logic [VERDICT_W-1:0] verdict;
	logic [ENTRY_W-1:0]   store_entry;
	logic [SEQ_W-1:0]     ack_number;
	logic                 last;

	modport source (output valid, output kind, output write_offset, output write_length,
		output from_buffer, output source_entry, output verdict, output store_entry,
		output ack_number, output last, input ready);
	modport sink   (input valid, input kind, input write_offset, input write_length,
		input from_buffer, input source_entry, input verdict, input store_entry,
		input ack_number, input last, output ready);
endinterface

### src/reorder_buffer_cumulative_ack.sv
// ----------------------------------------------------------------------------
// Reorder buffer with cumulative ack
// Receiver-side segment reordering: releases in-order segments, drains the
// out-of-order table, stores later segments in a free entry, acks every data beat.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  segment   in   seq_number, data_length (zero length = end of stream)
//  result    out  kind, write_offset/length, from_buffer, source_entry,
//                 verdict, store_entry, ack_number, last
//
// One segment at a time. Each table scan reads the entry memory one entry per
// cycle and stops at a hit. In order: the segment is released, then the table is
// scanned again after each entry drained. Later segment: one scan for a copy and
// a free entry. Duplicate or end of stream: no scan. Output stalls hold the
// machine.
// Reset clears the expected number and the valid bits; no memory sweep.
// ----------------------------------------------------------------------------
module reorder_buffer_cumulative_ack import rbca_pkg::*; #(
	parameter int BUFFER_DEPTH = 16,
	parameter int MAX_PAYLOAD  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	rbca_seg_if.sink    segment,
	rbca_res_if.source  result
);

	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		S_IDLE, S_EOS, S_REL_IN, S_DRAIN, S_REL_BUF, S_HOLD_SCAN, S_ACK
	} state_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
	} entry_t;

	state_t              state_q;
	res_t                out_q;
	logic                out_valid_q;
	logic [SEQ_W-1:0]    expected_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [LEN_W-1:0]    len_q;
	logic [BUFFER_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_s1;
	logic                vld_s1;
	logic                free_found_q;
	logic [IDX_W-1:0]    store_q;
	verdict_t            verdict_q;

	entry_t              mem [BUFFER_DEPTH];
	entry_t              rd_s1;

	logic                slot_free;
	logic                emit;
	logic [LEN_W-1:0]    sat_len;
	logic [SEQ_W-1:0]    key;
	logic                hit;
	logic                scan_end;
	logic                mem_re;
	logic                mem_we;
	logic [IDX_W-1:0]    rd_addr;
	logic                free_now;
	logic [IDX_W-1:0]    free_idx;
	logic [SEQ_W-1:0]    exp_in_sum;
	logic [SEQ_W-1:0]    exp_buf_sum;

	assign slot_free = !out_valid_q || result.ready;
	// a result beat is loaded this cycle
	assign emit      = slot_free && ((state_q == S_EOS) || (state_q == S_REL_IN)
		|| (state_q == S_REL_BUF) || (state_q == S_ACK));
	assign sat_len   = (16'(segment.data_length) > MAX_LEN) ? MAX_LEN[LEN_W-1:0]
		: segment.data_length;

	// key: expected number while draining, arriving number while looking for a copy
	assign key      = (state_q == S_DRAIN) ? expected_q : seq_q;
	assign hit      = vld_s1 && valid_q[idx_s1] && (rd_s1.seq == key);
	assign scan_end = vld_s1 && (idx_s1 == LAST_IDX);
	assign rd_addr  = idx_q[IDX_W-1:0];
	assign mem_re   = ((state_q == S_DRAIN) || (state_q == S_HOLD_SCAN))
		&& (idx_q < DEPTH_CNT) && !hit;

	assign free_now = free_found_q || (vld_s1 && !valid_q[idx_s1]);
	assign free_idx = free_found_q ? store_q : idx_s1;
	assign mem_we   = (state_q == S_HOLD_SCAN) && scan_end && !hit && free_now;

	assign exp_in_sum  = expected_q + SEQ_W'(len_q);
	assign exp_buf_sum = expected_q + SEQ_W'(rd_s1.len);

	// entry memory: read data is held while no read is issued
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx] <= '{seq: seq_q, len: len_q};
		end
		if (mem_re) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			expected_q   <= '0;
			seq_q        <= '0;
			len_q        <= '0;
			valid_q      <= '0;
			idx_q        <= '0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
			store_q      <= '0;
			verdict_q    <= V_IN_ORDER;
		end else begin
			if (result.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= mem_re;
			if (mem_re) begin
				idx_s1 <= rd_addr;
				idx_q  <= idx_q + 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (segment.valid) begin
						seq_q        <= segment.seq_number;
						len_q        <= sat_len;
						idx_q        <= '0;
						free_found_q <= 1'b0;
						store_q      <= '0;
						if (segment.data_length == '0) begin
							state_q <= S_EOS;
						end else if (segment.seq_number == expected_q) begin
							state_q <= S_REL_IN;
						end else if (segment.seq_number > expected_q) begin
							state_q <= S_HOLD_SCAN;
						end else begin
							verdict_q <= V_DUPLICATE;
							state_q   <= S_ACK;
						end
					end
				end
				S_EOS: begin
					if (slot_free) begin
						out_q <= make_result(KIND_EOS, '0, '0, 1'b0, '0, V_IN_ORDER, '0,
							expected_q, 1'b1);
						out_valid_q <= 1'b1;
						valid_q     <= '0;
						expected_q  <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_REL_IN: begin
					if (slot_free) begin
						out_q <= make_result(KIND_RELEASE, seq_q, len_q, 1'b0, '0, V_IN_ORDER,
							'0, exp_in_sum, 1'b0);
						out_valid_q <= 1'b1;
						expected_q  <= exp_in_sum;
						idx_q       <= '0;
						state_q     <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (hit) begin
						state_q <= S_REL_BUF;
					end else if (scan_end) begin
						verdict_q <= V_IN_ORDER;
						store_q   <= '0;
						state_q   <= S_ACK;
					end
				end
				S_REL_BUF: begin
					if (slot_free) begin
						out_q <= make_result(KIND_RELEASE, rd_s1.seq, rd_s1.len, 1'b1,
							ENTRY_W'(idx_s1), V_IN_ORDER, '0, exp_buf_sum, 1'b0);
						out_valid_q     <= 1'b1;
						valid_q[idx_s1] <= 1'b0;
						expected_q      <= exp_buf_sum;
						idx_q           <= '0;
						state_q         <= S_DRAIN;
					end
				end
				S_HOLD_SCAN: begin
					if (hit) begin
						verdict_q <= V_HELD;
						store_q   <= '0;
						state_q   <= S_ACK;
					end else if (scan_end) begin
						if (free_now) begin
							valid_q[free_idx] <= 1'b1;
							verdict_q         <= V_BUFFERED;
							store_q           <= free_idx;
						end else begin
							verdict_q <= V_DROPPED;
							store_q   <= '0;
						end
						state_q <= S_ACK;
					end else if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
						// remember the lowest free entry seen so far
						free_found_q <= 1'b1;
						store_q      <= idx_s1;
					end
				end
				S_ACK: begin
					if (slot_free) begin
						out_q <= make_result(KIND_ACK, '0, '0, 1'b0, '0, verdict_q,
							ENTRY_W'(store_q), expected_q, 1'b1);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign segment.ready       = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.kind         = out_q.kind;
	assign result.write_offset = out_q.write_offset;
	assign result.write_length = out_q.write_length;
	assign result.from_buffer  = out_q.from_buffer;
	assign result.source_entry = out_q.source_entry;
	assign result.verdict      = out_q.verdict;
	assign result.store_entry  = out_q.store_entry;
	assign result.ack_number   = out_q.ack_number;
	assign result.last         = out_q.last;

endmodule

### src/rbca_checker.sv
// ----------------------------------------------------------------------------
// Reorder buffer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbca_checker import rbca_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [KIND_W-1:0]    res_kind,
	input logic [SEQ_W-1:0]     res_offset,
	input logic [LEN_W-1:0]     res_length,
	input logic [VERDICT_W-1:0] res_verdict,
	input logic [ENTRY_W-1:0]   res_store,
	input logic [SEQ_W-1:0]     res_ack,
	input logic                 res_last
);

	// a stalled beat keeps its kind, ack, offset and last flag
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_ack) && $stable(res_offset) && $stable(res_last))

	// only acks and end of stream close an item
	`ASSERT_IMPLIES(a_last_kind, clk, arst_n, res_valid, res_last == (res_kind != KIND_RELEASE))

	// a release advances the expected number by exactly its length
	`ASSERT_IMPLIES(a_rel_ack, clk, arst_n, res_valid && (res_kind == KIND_RELEASE), res_ack == res_offset + SEQ_W'(res_length))

	// store entry is meaningful on buffered acks only
	`ASSERT_IMPLIES(a_store_zero, clk, arst_n, res_valid && (res_verdict != V_BUFFERED), res_store == '0)

endmodule

bind reorder_buffer_cumulative_ack rbca_checker u_rbca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_kind    (result.kind),
	.res_offset  (result.write_offset),
	.res_length  (result.write_length),
	.res_verdict (result.verdict),
	.res_store   (result.store_entry),
	.res_ack     (result.ack_number),
	.res_last    (result.last)
);
